FILE: hw/rtl/altitude_slew_and_climb_fail_latch_unit_macros.svh
// assertion macros for the altitude slew and climb-fail latch unit
`ifndef ALTITUDE_SLEW_AND_CLIMB_FAIL_LATCH_UNIT_MACROS_SVH
`define ALTITUDE_SLEW_AND_CLIMB_FAIL_LATCH_UNIT_MACROS_SVH

// clocked check, muted while reset is held
`define ASCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define ASCF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ascf_pkg.sv
// shared types, constants and helpers of the altitude slew unit
package ascf_pkg;

  // item kinds
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ENGAGE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_RATE     = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_DEADBAND = 2'd2;

  // configuration reset values
  localparam logic [13:0] RATE_RST     = 14'd2000;
  localparam logic [14:0] TIMEOUT_RST  = 15'd10000;
  localparam logic [13:0] DEADBAND_RST = 14'd500;

  // time and length units
  localparam logic [13:0] UM_PER_CM  = 14'd10000;
  localparam logic [13:0] HALF_CM_UM = 14'd5000;
  localparam logic [9:0]  NOM_DT_MS  = 10'd20;
  localparam logic [31:0] MAX_DT_MS  = 32'd1000;

  // floor(x / 10000) = (x * RECIP_CM) >> RECIP_SHIFT, exact for x below 2^24
  localparam logic [23:0] RECIP_CM    = 24'd13743896;
  localparam int          RECIP_SHIFT = 37;

  typedef logic signed [24:0] alt_cm_t;
  typedef logic [13:0]        rem_um_t;
  typedef logic [10:0]        step_cm_t;

  // operands of the slew step; target is tgt_q cm plus tgt_r um, tgt_r below 10000
  typedef struct packed {
    alt_cm_t  cmd;
    alt_cm_t  tgt_q;
    rem_um_t  tgt_r;
    step_cm_t step_cm;
    rem_um_t  step_rem;
  } slew_in_t;

  typedef struct packed {
    alt_cm_t tgt_q;
    rem_um_t tgt_r;
  } slew_out_t;

  // round a split cm/um target to cm, half away from zero
  function automatic alt_cm_t round_cm(input alt_cm_t q, input rem_um_t r);
    logic up;
    up = (q < 0) ? (r > HALF_CM_UM) : (r >= HALF_CM_UM);
    return q + $signed({24'b0, up});
  endfunction

endpackage

FILE: hw/rtl/ascf_in_if.sv
// input channel of the altitude slew unit
interface ascf_in_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [31:0]         now_ms;
  logic signed [24:0]  current_alt_cm;
  logic                demand_limited;

  modport source (output valid, cmd, now_ms, current_alt_cm, demand_limited, input ready);
  modport sink (input valid, cmd, now_ms, current_alt_cm, demand_limited, output ready);
endinterface

FILE: hw/rtl/ascf_out_if.sv
// result channel of the altitude slew unit
interface ascf_out_if;
  logic                valid;
  logic                ready;
  logic signed [24:0]  target_alt_cm;
  logic                fail_latched;
  logic                fail_event;

  modport source (output valid, target_alt_cm, fail_latched, fail_event, input ready);
  modport sink (input valid, target_alt_cm, fail_latched, fail_event, output ready);
endinterface

FILE: hw/rtl/ascf_slew.sv
// rate-limited move of the split cm/um target toward the commanded altitude
module ascf_slew (
  input  ascf_pkg::slew_in_t  si,
  output ascf_pkg::slew_out_t so
);

  logic signed [26:0] err_cm;
  logic signed [26:0] sc_s;
  logic signed [26:0] up_lim;
  logic signed [26:0] dn_sum;
  logic [14:0]        t_sum;
  logic [14:0]        r_wrap;
  logic               carry;
  logic               borrow;
  logic               r_gt;
  logic               go_up;
  logic               go_dn;

  // compare the um distance against the step without any multiply
  always_comb begin
    err_cm = 27'(si.cmd) - 27'(si.tgt_q);
    sc_s   = $signed({16'b0, si.step_cm});
    t_sum  = {1'b0, si.tgt_r} + {1'b0, si.step_rem};
    carry  = (t_sum >= {1'b0, ascf_pkg::UM_PER_CM});
    borrow = (si.tgt_r < si.step_rem);
    r_gt   = (si.tgt_r > si.step_rem);
    up_lim = sc_s + $signed({26'b0, carry});
    dn_sum = err_cm + sc_s;
    go_up  = (err_cm > up_lim);
    go_dn  = (dn_sum < $signed({26'b0, r_gt}));
    r_wrap = {1'b0, si.tgt_r} + {1'b0, ascf_pkg::UM_PER_CM} - {1'b0, si.step_rem};
  end

  // full step up, full step down, or land on the command
  always_comb begin
    priority if (go_up) begin
      so.tgt_q = 25'(27'(si.tgt_q) + sc_s + $signed({26'b0, carry}));
      so.tgt_r = carry ? 14'(t_sum - {1'b0, ascf_pkg::UM_PER_CM}) : t_sum[13:0];
    end else if (go_dn) begin
      so.tgt_q = 25'(27'(si.tgt_q) - sc_s - $signed({26'b0, borrow}));
      so.tgt_r = borrow ? r_wrap[13:0] : (si.tgt_r - si.step_rem);
    end else begin
      so.tgt_q = si.cmd;
      so.tgt_r = '0;
    end
  end

endmodule

FILE: hw/rtl/altitude_slew_and_climb_fail_latch_unit.sv
// top level of the altitude slew and climb-fail latch unit
`include "altitude_slew_and_climb_fail_latch_unit_macros.svh"

// Altitude target slew with a climb-failure latch.
// in_ch carries one item per transfer: cmd selects an engage (snapshot of
// current_alt_cm as command and target, latch cleared) or a periodic tick.
// Every item gives exactly one result on out_ch: the slewed target rounded to
// cm, the latch state and a one-shot flag on the tick that latches.
// Configuration (climb rate, timeout, deadband) is written through cfg_we,
// cfg_idx and cfg_wdata; index 3 is ignored. The user must write it only
// while no item is in flight; the block itself does not enforce this.
// Timing: an item passes three registers (step product, step split to cm
// and um, then the state update with the result register). One item is
// taken every cycle while out_ch is not stalled; the state loop closes
// within the last stage, so back-to-back ticks see the state left by the
// item before them. Reset: configuration returns to 2000 mm/s, 10000 ms
// and 500 cm, the state to zero, and all stages empty.
// A stalled receiver holds the result; the stages in front keep filling
// their empty slots and in_ch.ready drops only once all of them are full.
module altitude_slew_and_climb_fail_latch_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [14:0]      cfg_wdata,
  ascf_in_if.sink          in_ch,
  ascf_out_if.source       out_ch
);

  // configuration
  logic [13:0] rate_r;
  logic [14:0] timeout_r;
  logic [13:0] deadband_r;

  // block state
  logic [31:0]         last_now_r;
  logic [31:0]         tstart_r;
  logic [31:0]         tstart_nxt;
  logic                running_r;
  logic                running_nxt;
  logic                latched_r;
  logic                latched_nxt;
  ascf_pkg::alt_cm_t   cmd_r;
  ascf_pkg::alt_cm_t   cmd_nxt;
  ascf_pkg::alt_cm_t   tgt_q_r;
  ascf_pkg::alt_cm_t   tgt_q_nxt;
  ascf_pkg::rem_um_t   rem_r;
  ascf_pkg::rem_um_t   rem_nxt;

  // stage 1: step in um
  logic                s1_valid_r;
  logic                s1_cmd_r;
  logic [31:0]         s1_now_r;
  ascf_pkg::alt_cm_t   s1_alt_r;
  logic                s1_lim_r;
  logic [23:0]         s1_step_r;

  // stage 2: step split into cm
  logic                s2_valid_r;
  logic                s2_cmd_r;
  logic [31:0]         s2_now_r;
  ascf_pkg::alt_cm_t   s2_alt_r;
  logic                s2_lim_r;
  logic [23:0]         s2_step_r;
  ascf_pkg::step_cm_t  s2_scm_r;

  // result register
  logic                out_valid_r;
  ascf_pkg::alt_cm_t   out_tgt_r;
  logic                out_lat_r;
  logic                out_evt_r;

  // handshake
  logic out_adv;
  logic s1_ready;
  logic in_ready;
  logic in_xfer;
  logic st_en;

  // combinational values
  logic [31:0]         dt_raw;
  logic [9:0]          dt_ms;
  logic [23:0]         step_nxt;
  logic [47:0]         recip_prod;
  ascf_pkg::step_cm_t  scm_nxt;
  logic [23:0]         step_cm_um;
  logic [23:0]         step_rem_full;
  ascf_pkg::rem_um_t   step_rem_um;
  logic signed [25:0]  err_cm;
  logic [25:0]         err_mag;
  logic                above_db;
  logic [31:0]         elapsed_ms;
  logic                timed_out;
  logic                evt_nxt;
  ascf_pkg::alt_cm_t   cmd_w;
  ascf_pkg::alt_cm_t   q_w;
  ascf_pkg::rem_um_t   r_w;
  ascf_pkg::slew_in_t  slew_in;
  ascf_pkg::slew_out_t slew_out;

  // stage advance: each stage moves when its successor has room
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s2_valid_r || out_adv;
  assign in_ready    = !s1_valid_r || s1_ready;
  assign in_xfer     = in_ch.valid && in_ready;
  assign st_en       = s2_valid_r && out_adv;
  assign in_ch.ready = in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= ascf_pkg::RATE_RST;
      timeout_r  <= ascf_pkg::TIMEOUT_RST;
      deadband_r <= ascf_pkg::DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ascf_pkg::CFG_RATE:     rate_r     <= cfg_wdata[13:0];
        ascf_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
        ascf_pkg::CFG_DEADBAND: deadband_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  // ms since the last item (20 if 0 or above 1000) times the climb rate
  always_comb begin
    dt_raw   = in_ch.now_ms - last_now_r;
    dt_ms    = (dt_raw == '0 || dt_raw > ascf_pkg::MAX_DT_MS) ? ascf_pkg::NOM_DT_MS
                                                                : dt_raw[9:0];
    step_nxt = {10'b0, rate_r} * {14'b0, dt_ms};
  end

  // stage 1 registers and the time of the last item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      last_now_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (in_xfer) begin
        last_now_r <= in_ch.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_ch.cmd;
      s1_now_r  <= in_ch.now_ms;
      s1_alt_r  <= in_ch.current_alt_cm;
      s1_lim_r  <= in_ch.demand_limited;
      s1_step_r <= step_nxt;
    end
  end

  // whole cm of the step by reciprocal multiply
  assign recip_prod = {24'b0, s1_step_r} * {24'b0, ascf_pkg::RECIP_CM};
  assign scm_nxt    = 11'(recip_prod >> ascf_pkg::RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_ready) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_now_r  <= s1_now_r;
      s2_alt_r  <= s1_alt_r;
      s2_lim_r  <= s1_lim_r;
      s2_step_r <= s1_step_r;
      s2_scm_r  <= scm_nxt;
    end
  end

  // leftover um of the step, error against the deadband, timer age
  always_comb begin
    step_cm_um    = {13'b0, s2_scm_r} * {10'b0, ascf_pkg::UM_PER_CM};
    step_rem_full = s2_step_r - step_cm_um;
    step_rem_um   = step_rem_full[13:0];
    err_cm        = 26'(cmd_r) - 26'(s2_alt_r);
    err_mag       = (err_cm < 0) ? 26'(-err_cm) : 26'(err_cm);
    above_db      = (err_mag > {12'b0, deadband_r});
    elapsed_ms    = s2_now_r - tstart_r;
    timed_out     = (elapsed_ms > {17'b0, timeout_r});
  end

  // persistence timer and failure latch: cleared on an engage, run on a tick until it latches
  always_comb begin
    running_nxt = running_r;
    tstart_nxt  = tstart_r;
    latched_nxt = latched_r;
    evt_nxt     = 1'b0;
    cmd_w       = cmd_r;
    q_w         = tgt_q_r;
    r_w         = rem_r;
    if (s2_cmd_r == ascf_pkg::CMD_ENGAGE) begin
      running_nxt = 1'b0;
      tstart_nxt  = '0;
      latched_nxt = 1'b0;
    end else if (!latched_r) begin
      if (above_db && s2_lim_r) begin
        if (!running_r) begin
          running_nxt = 1'b1;
          tstart_nxt  = s2_now_r;
        end else if (timed_out) begin
          latched_nxt = 1'b1;
          evt_nxt     = 1'b1;
          cmd_w       = s2_alt_r;
          q_w         = s2_alt_r;
          r_w         = '0;
        end
      end else begin
        running_nxt = 1'b0;
      end
    end
  end

  assign slew_in = '{cmd: cmd_w, tgt_q: q_w, tgt_r: r_w,
                     step_cm: s2_scm_r, step_rem: step_rem_um};

  ascf_slew u_slew (
    .si (slew_in),
    .so (slew_out)
  );

  // engage snaps everything to the current altitude
  always_comb begin
    if (s2_cmd_r == ascf_pkg::CMD_ENGAGE) begin
      cmd_nxt   = s2_alt_r;
      tgt_q_nxt = s2_alt_r;
      rem_nxt   = '0;
    end else begin
      cmd_nxt   = cmd_w;
      tgt_q_nxt = slew_out.tgt_q;
      rem_nxt   = slew_out.tgt_r;
    end
  end

  // state update, taken together with the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tstart_r  <= '0;
      running_r <= 1'b0;
      latched_r <= 1'b0;
      cmd_r     <= '0;
      tgt_q_r   <= '0;
      rem_r     <= '0;
    end else if (st_en) begin
      tstart_r  <= tstart_nxt;
      running_r <= running_nxt;
      latched_r <= latched_nxt;
      cmd_r     <= cmd_nxt;
      tgt_q_r   <= tgt_q_nxt;
      rem_r     <= rem_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_en) begin
      out_tgt_r <= ascf_pkg::round_cm(tgt_q_nxt, rem_nxt);
      out_lat_r <= latched_nxt;
      out_evt_r <= evt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.target_alt_cm = out_tgt_r;
  assign out_ch.fail_latched  = out_lat_r;
  assign out_ch.fail_event    = out_evt_r;

  // checks
  `ASCF_ASSERT(a_latch_has_event, $rose(latched_r) |-> out_valid_r && out_evt_r, "latch rose without an event result")
  `ASCF_ASSERT(a_rem_range, rem_r < ascf_pkg::UM_PER_CM, "target um remainder out of range")
  `ASCF_ASSERT(a_step_split, s2_valid_r |-> step_rem_um < ascf_pkg::UM_PER_CM && step_rem_full[23:14] == '0, "step split into cm and um is off")
  `ASCF_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule
